// ===== design/b2da_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

   localparam int DEC_SLOTS  = 10;                 // digits of a 31-bit magnitude
   localparam int BCD_W      = 4 * DEC_SLOTS;
   localparam int MAG_W      = 31;                 // magnitude bits of a non-negative value
   localparam int CONV_STEPS = MAG_W;              // one shift per magnitude bit
   localparam int STEP_W     = 5;
   localparam int IDX_W      = 4;
   localparam int CHAR_W     = 6;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture value, clear BCD
      logic shift;    // one add-3 and shift step
      logic size;     // find digit count, set digit index
      logic emit;     // drive one digit, step index down
   } b2da_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic neg;        // incoming value is negative
      logic conv_done;  // final shift step this cycle
      logic emit_last;  // least significant digit this cycle
   } b2da_sts_type;

endpackage

`default_nettype wire

// ===== design/b2da_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b2da_ctrl
   import b2da_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire b2da_sts_type sts,
   output b2da_cmd_type      cmd,
   output logic              busy
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIZE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !sts.neg) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== design/b2da_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module b2da_dpath
   import b2da_pkg::*;
#(
   parameter int MAX_DIGITS = 10
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       req_value,
   input  wire b2da_cmd_type      cmd,
   output b2da_sts_type           sts,
   output logic                   rsp_strobe,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last
);

   localparam int KEEP_CAP = (MAX_DIGITS < DEC_SLOTS) ? MAX_DIGITS : DEC_SLOTS;

   logic [MAG_W-1:0]  bin_ff,  bin_in;
   logic [BCD_W-1:0]  bcd_ff,  bcd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  idx_ff,  idx_in;
   logic              strobe_ff;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   logic [BCD_W-1:0]  bcd_adj;
   logic [IDX_W-1:0]  count;
   logic [IDX_W-1:0]  keep;
   logic [3:0]        cur_digit;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_SLOTS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // significant digits: highest nonzero digit, at least one
   always_comb begin
      count = IDX_W'(1);
      for (int i = 0; i < DEC_SLOTS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            count = IDX_W'(i + 1);
         end
      end
      keep = (count > IDX_W'(KEEP_CAP)) ? IDX_W'(KEEP_CAP) : count;
   end

   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         bin_in  = req_value[MAG_W-1:0];
         bcd_in  = '0;
         step_in = '0;
      end
      if (cmd.shift) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[MAG_W-1]};
         bin_in  = {bin_ff[MAG_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.size) begin
         idx_in = keep - IDX_W'(1);
      end
      if (cmd.emit) begin
         char_in = ASCII_ZERO + {2'b00, cur_digit};
         last_in = (idx_ff == '0);
         idx_in  = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign sts.neg       = req_value[31];
   assign sts.conv_done = (step_ff == STEP_W'(CONV_STEPS - 1));
   assign sts.emit_last = (idx_ff == '0);

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

// ===== design/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Once start is taken and the value converted, the digits strobe out one per cycle.
// Each item passes through idle, the 31-step shift-and-add-3 loop, a sizing step and
//   the emit of its N digits (N = digits sent, 1..10); a new item is taken only in idle;
//   a negative item is dropped in idle.
// Results cannot be stalled: rsp_strobe marks each digit for exactly one cycle.
// Reset (synchronous, active high) returns the controller to idle and drops rsp_strobe.

module binary_to_decimal_ascii_unit
   import b2da_pkg::*;
#(
   parameter int MAX_DIGITS = 10   // most digits in one run, 1..10; larger values act as 10
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [31:0]       req_value,
   output logic                   rsp_strobe,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last
);

   // Controller sequences: idle -> convert (31 shifts) -> size -> emit (N).
   // A negative item is taken in idle and dropped: no digits, busy stays low.
   // The datapath holds the magnitude, the 10-digit BCD register, the step
   // counter, the digit index and the registered result.
   // Digits come out most significant first; with more digits than MAX_DIGITS
   // only the low MAX_DIGITS go out, zeros in front included.

   b2da_cmd_type cmd;
   b2da_sts_type sts;

   b2da_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   b2da_dpath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/binary_to_decimal_ascii_unit_tb.sv =====
`timescale 1ns / 1ps

module binary_to_decimal_ascii_unit_tb;
   import b2da_pkg::*;

   // Digit limit used for the instance; the expected-digit model below follows it.
   localparam int DIGIT_LIMIT = 10;
   localparam int RADIX       = 10;

   // One emitted character as seen on the result ports.
   typedef struct {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_item_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [31:0]       req_value;
   logic              rsp_strobe;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic              rsp_last;

   // Characters still owed by the block, oldest first.
   digit_item_type pending_digits[$];
   int             fail_count;
   // Chance, in percent, that the sender holds start low in a given cycle.
   int             sender_idle_pct;

   binary_to_decimal_ascii_unit #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last(rsp_last)
   );

   // 20 ns clock period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Expected digits for one value. Negative values give nothing; zero
   // gives a lone '0'. Otherwise digits are peeled from the low end and
   // the lowest DIGIT_LIMIT of them are queued, most significant first,
   // with last set on the units digit.
   // ------------------------------------------------------------------
   task automatic queue_decimal_digits(input logic [31:0] value);
      logic [3:0]     dec_digit [DEC_SLOTS];
      logic [31:0]    rest;
      int             count;
      int             keep;
      digit_item_type item;
      if (value[31]) begin
         return;
      end
      if (value == 32'd0) begin
         item.digit_char = ASCII_ZERO;
         item.last       = 1'b1;
         pending_digits.push_back(item);
         return;
      end
      rest  = value;
      count = 0;
      while (rest != 32'd0 && count < DEC_SLOTS) begin
         dec_digit[count] = 4'(rest % RADIX);
         rest             = rest / RADIX;
         count++;
      end
      keep = (count > DIGIT_LIMIT) ? DIGIT_LIMIT : count;
      if (keep < 1) begin
         keep = 1;
      end
      for (int k = 0; k < keep; k++) begin
         item.digit_char = ASCII_ZERO + CHAR_W'(dec_digit[keep - 1 - k]);
         item.last       = (k == keep - 1);
         pending_digits.push_back(item);
      end
   endtask

   // ------------------------------------------------------------------
   // Send one item. Drives on the falling edge; each cycle the sender
   // idles with chance sender_idle_pct, else offers the item. The item
   // is taken at the first rising edge with start high and busy low.
   // ------------------------------------------------------------------
   task automatic send_value(input logic [31:0] value);
      logic taken;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
         end else begin
            start     <= 1'b1;
            req_value <= value;
         end
         @(posedge clock);
         taken = start && !busy;
      end
      queue_decimal_digits(value);
   endtask

   // Hold start low until every queued digit has been seen.
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_digits.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random value: some negatives, some tiny values, the rest spread over
   // every digit count by picking a random bit width.
   function automatic logic [31:0] random_value();
      int unsigned pick;
      int unsigned width;
      logic [31:0] value;
      pick  = $urandom_range(99);
      width = $urandom_range(1, 31);
      if (pick < 15) begin
         value = $urandom() | 32'h8000_0000;
      end else if (pick < 25) begin
         value = $urandom_range(0, 99);
      end else begin
         value = $urandom() >> (32 - width);
      end
      return value;
   endfunction

   task automatic run_random(input int n_items);
      for (int i = 0; i < n_items; i++) begin
         send_value(random_value());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Digit-count boundaries, internal zeros, zero, sign bit cases; sent
   // back to back so negatives and zeros also follow each other directly.
   task automatic test_directed_values();
      logic [31:0] values [$];
      values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd7, 32'd42,
                 32'd1000000000, 32'd999999999, 32'd2147483647, 32'd2147483646,
                 32'd1000000007, 32'd10203040, 32'd1073741824,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0000, 32'd0,
                 32'hFFFF_FFFB, 32'd12345};
      sender_idle_pct = 0;
      foreach (values[i]) begin
         send_value(values[i]);
      end
   endtask

   task automatic test_random_light_gaps();
      sender_idle_pct = 26;
      run_random(80);
   endtask

   task automatic test_random_heavy_gaps();
      sender_idle_pct = 70;
      run_random(80);
   endtask

   task automatic test_random_back_to_back();
      sender_idle_pct = 0;
      run_random(80);
   endtask

   // Short bursts with the sender fully quiet until the block has emptied.
   task automatic test_drain_pause();
      sender_idle_pct = 0;
      for (int r = 0; r < 8; r++) begin
         run_random($urandom_range(1, 3));
         wait_for_drain();
      end
   endtask

   // ------------------------------------------------------------------
   // Result checker: each strobe takes the oldest expected digit.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_strobe) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected digit: digit_char=%0d last=%0d", rsp_digit_char, rsp_last);
            fail_count++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $error("digit_char mismatch: expected %0d, got %0d",
                      want.digit_char, rsp_digit_char);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      fail_count      = 0;
      sender_idle_pct = 0;
      reset           = 1'b1;
      start           = 1'b0;
      req_value       = 32'd0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_random_light_gaps();
      test_random_heavy_gaps();
      test_random_back_to_back();
      test_drain_pause();

      // Let the last run of digits finish, then allow for stray strobes.
      wait_for_drain();
      repeat (60) @(posedge clock);

      if (fail_count == 0) begin
         $display("binary_to_decimal_ascii_unit regression: pass");
      end else begin
         $display("binary_to_decimal_ascii_unit regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~300 items
   // plus sender gaps).
   initial begin
      #5_000_000;
      $display("binary_to_decimal_ascii_unit regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/b2da_pkg.sv
design/b2da_ctrl.sv
design/b2da_dpath.sv
design/binary_to_decimal_ascii_unit.sv
tb/sv/binary_to_decimal_ascii_unit_tb.sv
